// ===== rtl/p2nn_pkg.sv =====
`default_nettype none

package p2nn_pkg;

	// Width of one RGBA pixel.
	localparam int PIXEL_W = 32;

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SOURCE_WIDTH  = 2'd0,
		CFG_SOURCE_HEIGHT = 2'd1
	} cfg_index_t;

	// Item kinds carried in the input tuser.
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Status of one coordinate from the mapping unit.
	typedef struct packed {
		logic in_source;    // Write coordinate lies inside the source frame.
		logic out_of_range; // Read coordinate lies outside the padded frame.
	} map_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/p2nn_ram.sv =====
`default_nettype none

module p2nn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/p2nn_map.sv =====
`default_nettype none

module p2nn_map
	import p2nn_pkg::*;
#(
	parameter int MAX_DIM = 64,
	localparam int COORD_W = $clog2(MAX_DIM),
	localparam int DIM_W = COORD_W + 1,
	localparam int ADDR_W = 2 * COORD_W
) (
	input  wire logic [DIM_W-1:0]   source_width,
	input  wire logic [DIM_W-1:0]   source_height,
	input  wire logic [COORD_W-1:0] coord_x,
	input  wire logic [COORD_W-1:0] coord_y,
	output logic      [DIM_W-1:0]   padded_width,
	output logic      [DIM_W-1:0]   padded_height,
	output logic      [ADDR_W-1:0]  wr_addr,
	output logic      [ADDR_W-1:0]  rd_addr,
	output map_ctl_t                ctl
);

	localparam int LG_W = $clog2(COORD_W + 1);
	localparam int PROD_W = COORD_W + DIM_W;

	logic [DIM_W-1:0]   eff_w, eff_h;
	logic [LG_W-1:0]    lg_w, lg_h;
	logic [PROD_W-1:0]  prod_x, prod_y;
	logic [PROD_W-1:0]  src_x, src_y;
	logic [DIM_W-1:0]   x_ext, y_ext;

	// Saturate the sizes: zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		eff_w = source_width;
		if (source_width == '0) begin
			eff_w = DIM_W'(1);
		end else if (source_width > DIM_W'(MAX_DIM)) begin
			eff_w = DIM_W'(MAX_DIM);
		end
		eff_h = source_height;
		if (source_height == '0) begin
			eff_h = DIM_W'(1);
		end else if (source_height > DIM_W'(MAX_DIM)) begin
			eff_h = DIM_W'(MAX_DIM);
		end
	end

	// Ceiling log2 of each size picks the padded power of two.
	always_comb begin
		lg_w = '0;
		lg_h = '0;
		for (int k = COORD_W; k >= 0; k--) begin
			if ((DIM_W'(1) << k) >= eff_w) begin
				lg_w = LG_W'(k);
			end
			if ((DIM_W'(1) << k) >= eff_h) begin
				lg_h = LG_W'(k);
			end
		end
	end

	assign padded_width  = DIM_W'(1) << lg_w;
	assign padded_height = DIM_W'(1) << lg_h;

	// The source coordinate is floor(x * size / padded), a shift by the padded log2.
	assign prod_x = PROD_W'(coord_x) * PROD_W'(eff_w);
	assign prod_y = PROD_W'(coord_y) * PROD_W'(eff_h);
	assign src_x  = prod_x >> lg_w;
	assign src_y  = prod_y >> lg_h;

	assign rd_addr = {src_y[COORD_W-1:0], src_x[COORD_W-1:0]};
	assign wr_addr = {coord_y, coord_x};

	assign x_ext = DIM_W'(coord_x);
	assign y_ext = DIM_W'(coord_y);

	// Range checks for both item kinds.
	always_comb begin
		ctl.in_source    = (x_ext < eff_w) && (y_ext < eff_h);
		ctl.out_of_range = (x_ext >= padded_width) || (y_ext >= padded_height)
			|| (src_x >= PROD_W'(eff_w)) || (src_y >= PROD_W'(eff_h));
	end

endmodule

`default_nettype wire

// ===== rtl/pow2_nearest_neighbour_resampler_core.sv =====
// Result path: a read item's result passes through the frame store read and then
// the output register; a write item gives no result.
// Throughput: one item per cycle, set by the single read and write port pair of
// the frame store; the input stalls only while a result waits at a stalled output.
// Reset: both size registers return to the maximum size; the frame store is not
// cleared and reads of unwritten pixels return arbitrary data.
`default_nettype none

module pow2_nearest_neighbour_resampler_core
	import p2nn_pkg::*;
#(
	parameter int MAX_DIM = 64,
	localparam int COORD_W = $clog2(MAX_DIM),
	localparam int DIM_W = COORD_W + 1,
	localparam int IN_W = 2 * COORD_W + PIXEL_W,
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W = PIXEL_W + 2 * DIM_W,
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input item stream.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // coord_x, coord_y, pixel_in
	input  wire logic                   s_tuser,   // operation
	// Result item stream.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,   // pixel_out, padded_width, padded_height
	output logic                        m_tuser,   // out_of_range
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]       cfg_data
);

	localparam int ADDR_W = 2 * COORD_W;

	logic [DIM_W-1:0]   source_width_q, source_height_q;
	logic [COORD_W-1:0] coord_x, coord_y;
	logic [PIXEL_W-1:0] pixel_in;
	logic [DIM_W-1:0]   padded_width, padded_height;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	map_ctl_t           ctl;
	logic               s_acc, ram_we, ram_re, out_adv;
	logic [PIXEL_W-1:0] ram_rdata;

	logic               valid_s1, oob_s1;
	logic [DIM_W-1:0]   pw_s1, ph_s1;

	logic               out_valid_q, out_oob_q;
	logic [PIXEL_W-1:0] out_pixel_q;
	logic [DIM_W-1:0]   out_pw_q, out_ph_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= DIM_W'(MAX_DIM);
			source_height_q <= DIM_W'(MAX_DIM);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				CFG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the input item.
	assign coord_x  = s_tdata[COORD_W-1:0];
	assign coord_y  = s_tdata[2*COORD_W-1:COORD_W];
	assign pixel_in = s_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];

	p2nn_map #(
		.MAX_DIM(MAX_DIM)
	) u_map (
		.source_width (source_width_q),
		.source_height(source_height_q),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.padded_width (padded_width),
		.padded_height(padded_height),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.ctl          (ctl)
	);

	// Handshake: the read stage moves on whenever the output register is free or drained.
	assign out_adv  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_adv;
	assign s_acc    = s_tvalid && s_tready;
	assign ram_we   = s_acc && (s_tuser == OP_WRITE) && ctl.in_source;
	assign ram_re   = s_acc && (s_tuser == OP_READ);

	p2nn_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(1 << ADDR_W)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(pixel_in),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Read stage: tracks the item whose frame store read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			oob_s1 <= ctl.out_of_range;
			pw_s1  <= padded_width;
			ph_s1  <= padded_height;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_pixel_q <= oob_s1 ? '0 : ram_rdata;
			out_oob_q   <= oob_s1;
			out_pw_q    <= pw_s1;
			out_ph_q    <= ph_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_oob_q;
	assign m_tdata  = OUT_TDATA_W'({out_ph_q, out_pw_q, out_pixel_q});

	// A read stage holds only behind a stalled output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s_tready) |-> (out_valid_q && !m_tready))
		else $error("read stage stalled without output back-pressure");

	// One item a cycle: the frame store never writes and reads in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("frame store written and read in one cycle");

	// An out-of-range result carries a zero pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (out_pixel_q == '0))
		else $error("out-of-range result with nonzero pixel");

	// Padded sizes are powers of two.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($onehot(out_pw_q) && $onehot(out_ph_q)))
		else $error("padded size is not a power of two");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import p2nn_pkg::*;

	localparam int FRAME_DIM = 64;
	localparam int RUN_LIMIT = 400000;
	localparam int PHASE_ITEMS = 128;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_WAIT = 16;

	// Register indexes past the end of the register list; writes to them are ignored.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

	typedef struct packed {
		op_t         op;
		logic [5:0]  x;
		logic [5:0]  y;
		logic [31:0] pixel;
	} pixel_req_t;

	typedef struct {
		logic [31:0] pixel;
		logic [6:0]  pw;
		logic [6:0]  ph;
		logic        flag;
	} resample_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;   // coord_x, coord_y, pixel_in
	logic s_tuser = 1'b0;        // operation
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;        // pixel_out, padded_width, padded_height
	logic m_tuser;               // out_of_range
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	pow2_nearest_neighbour_resampler_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Items waiting to be sent and results waiting to arrive.
	pixel_req_t pending_reqs[$];
	resample_result_t results_due[$];

	// Predictor copy of the block's state.
	logic [31:0] frame_copy [0:FRAME_DIM*FRAME_DIM-1];
	logic [6:0] width_reg = 7'd64;
	logic [6:0] height_reg = 7'd64;

	// Generator view of the frame, used to keep reads on written pixels.
	bit gen_written [0:FRAME_DIM*FRAME_DIM-1];
	int gen_sw = FRAME_DIM;
	int gen_sh = FRAME_DIM;
	int gen_pw = FRAME_DIM;
	int gen_ph = FRAME_DIM;

	int unsigned mismatches = 0;
	int unsigned items_accepted = 0;
	int unsigned cycle_count = 0;
	int unsigned write_count = 0;
	int unsigned read_count = 0;
	int unsigned flagged_reads = 0;
	int unsigned size_settings = 0;

	bit src_gaps_on = 1'b0;
	bit snk_stalls_on = 1'b0;
	logic sink_hold = 1'b0;
	int unsigned src_wait = 0;
	int unsigned snk_wait = 0;
	int unsigned snk_draw;
	pixel_req_t next_req;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Size register value as the block uses it, saturated to 1..FRAME_DIM.
	function automatic int eff_dim(input logic [6:0] v);
		if (v == 7'd0)
			return 1;
		if (int'(v) > FRAME_DIM)
			return FRAME_DIM;
		return int'(v);
	endfunction

	function automatic int pad_dim(input int v);
		int p;
		p = 1;
		while (p < v)
			p = p * 2;
		return p;
	endfunction

	// Nearest-neighbor prediction for one accepted item.
	function automatic void predict_item(input op_t op, input logic [5:0] x, input logic [5:0] y,
			input logic [31:0] pix);
		int sw, sh, pw, ph;
		resample_result_t res;
		sw = eff_dim(width_reg);
		sh = eff_dim(height_reg);
		if (op == OP_WRITE) begin
			if (int'(x) < sw && int'(y) < sh)
				frame_copy[{y, x}] = pix;
			return;
		end
		pw = pad_dim(sw);
		ph = pad_dim(sh);
		res.pixel = '0;
		res.pw = pw[6:0];
		res.ph = ph[6:0];
		res.flag = 1'b0;
		if (int'(x) >= pw || int'(y) >= ph) begin
			res.flag = 1'b1;
			flagged_reads++;
		end else begin
			res.pixel = frame_copy[(int'(y) * sh / ph) * FRAME_DIM + int'(x) * sw / pw];
		end
		results_due.insert(results_due.size(), res);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s is %h, expected %h", cycle_count, what, got, want);
		mismatches++;
	endtask

	// Generator side: queue items and keep track of which pixels hold data.
	task automatic queue_write(input int x, input int y, input logic [31:0] pix);
		pending_reqs.insert(pending_reqs.size(), pixel_req_t'{OP_WRITE, x[5:0], y[5:0], pix});
		if (x < gen_sw && y < gen_sh)
			gen_written[y * FRAME_DIM + x] = 1'b1;
		write_count++;
	endtask

	task automatic queue_read(input int x, input int y);
		int sx, sy;
		if (x < gen_pw && y < gen_ph) begin
			sx = x * gen_sw / gen_pw;
			sy = y * gen_sh / gen_ph;
			if (!gen_written[sy * FRAME_DIM + sx])
				queue_write(sx, sy, $urandom);
		end
		pending_reqs.insert(pending_reqs.size(),
			pixel_req_t'{OP_READ, x[5:0], y[5:0], $urandom});
		read_count++;
	endtask

	// The block is idle once nothing is queued, offered or expected, plus its latency.
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(input logic [6:0] w, input logic [6:0] h);
		write_register(CFG_SOURCE_WIDTH, w);
		write_register(CFG_SOURCE_HEIGHT, h);
		gen_sw = eff_dim(w);
		gen_sh = eff_dim(h);
		gen_pw = pad_dim(gen_sw);
		gen_ph = pad_dim(gen_sh);
		size_settings++;
	endtask

	// Input driver: one item per handshake, with a random gap before the next one while gaps are enabled.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_wait != 0) begin
				s_tvalid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.op;
				s_tdata <= {4'b0, next_req.pixel, next_req.y, next_req.x};
				src_wait <= src_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result ready: a random stall after each item while stalls are enabled, and the long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			snk_draw = snk_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
			snk_wait <= snk_draw;
			m_tready <= (snk_draw == 0) && !sink_hold;
		end else if (snk_wait != 0) begin
			snk_wait <= snk_wait - 1;
			m_tready <= (snk_wait == 1) && !sink_hold;
		end else begin
			m_tready <= !sink_hold;
		end
	end

	// Predictor: follows accepted items and register writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SOURCE_WIDTH)
					width_reg <= cfg_data;
				else if (cfg_index == CFG_SOURCE_HEIGHT)
					height_reg <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_item(op_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[43:12]);
				items_accepted++;
			end
		end
	end

	// Result checker: compares each result item with the oldest expectation.
	always @(posedge clk) begin : check_results
		resample_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with none expected, pixel", m_tdata[31:0], '0);
			end else begin
				want = results_due.pop_front();
				if (m_tdata[31:0] !== want.pixel)
					report_mismatch("pixel_out", m_tdata[31:0], want.pixel);
				if (m_tdata[38:32] !== want.pw)
					report_mismatch("padded_width", 32'(m_tdata[38:32]), 32'(want.pw));
				if (m_tdata[45:39] !== want.ph)
					report_mismatch("padded_height", 32'(m_tdata[45:39]), 32'(want.ph));
				if (m_tuser !== want.flag)
					report_mismatch("out_of_range", 32'(m_tuser), 32'(want.flag));
			end
		end
	end

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				results_due.size());
			$display("FAIL");
			$finish;
		end
	end

	// Long receiver hold-off in the middle of the random part, so the block backs up.
	initial begin
		wait (items_accepted >= 700);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin : stimulus
		int phase_w [8] = '{64, 1, 0, 127, 5, 64, 1, 17};
		int phase_h [8] = '{64, 1, 127, 0, 3, 1, 64, 33};
		int w, h, pick, phase_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Corners of the full-size frame at reset sizes.
		queue_write(0, 0, 32'h0000_0000);
		queue_write(63, 63, 32'hFFFF_FFFF);
		queue_write(63, 0, 32'hAAAA_AAAA);
		queue_write(0, 63, 32'h5555_5555);
		queue_read(0, 0);
		queue_read(63, 63);
		queue_read(63, 0);
		queue_read(0, 63);
		wait_idle();

		// Unused register indexes, then an odd-sized frame with writes outside it.
		write_register(CFG_UNUSED_LO, 7'h7F);
		write_register(CFG_UNUSED_HI, 7'h2A);
		set_size(7'd5, 7'd3);
		queue_write(4, 2, 32'h1234_5678);
		queue_write(5, 0, 32'hDEAD_BEEF);
		queue_write(0, 3, 32'hCAFE_F00D);
		queue_read(7, 3);
		queue_read(8, 0);
		queue_read(0, 4);
		queue_read(63, 63);
		wait_idle();

		// Zero and oversized register values saturate.
		set_size(7'd0, 7'd127);
		queue_read(0, 0);
		queue_read(1, 0);
		queue_read(0, 63);
		wait_idle();

		// Random phases: fixed sizes first, some of them extreme, then random sizes.
		for (int phase = 0; phase < 12; phase++) begin
			if (phase < 8) begin
				w = phase_w[phase];
				h = phase_h[phase];
			end else begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
			end
			set_size(w[6:0], h[6:0]);
			src_gaps_on = (phase == 1) || (phase != 0 && $urandom_range(0, 3) != 0);
			snk_stalls_on = (phase == 1) || (phase != 0 && $urandom_range(0, 3) != 0);
			phase_start = write_count + read_count;
			while (write_count + read_count - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					queue_read($urandom_range(0, gen_pw - 1), $urandom_range(0, gen_ph - 1));
				else if (pick < 85)
					queue_write($urandom_range(0, gen_sw - 1), $urandom_range(0, gen_sh - 1),
						$urandom);
				else if (pick < 93)
					queue_read($urandom_range(0, 63), $urandom_range(0, 63));
				else
					queue_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d pixel writes and %0d reads over %0d frame size settings,",
			write_count, read_count, size_settings);
		$display("of which %0d reads fell outside the padded frame; %0d mismatches.",
			flagged_reads, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/p2nn_pkg.sv
rtl/p2nn_ram.sv
rtl/p2nn_map.sv
rtl/pow2_nearest_neighbour_resampler_core.sv
test/tb.sv
